/* sv/vtc_pkg.sv */
package vtc_pkg;

  localparam int unsigned Q_SHIFT   = 16;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned DIV_STEPS = 33;  // quotient bits 32..0
  localparam int unsigned DOT_W     = 50;  // signed width of a column sum

  typedef logic signed [31:0]        coord_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic [DOT_W-1:0]          mag_t;
  typedef logic [3:0][3:0][31:0]     mat_t;   // [row][col]
  typedef logic [NUM_REGS-1:0][63:0] cfg_regs_t;

  // one divider pipeline stage, three lanes sharing a divisor
  typedef struct packed {
    logic                       last;
    logic                       dz;
    mag_t                       ad;
    logic [2:0]                 neg;
    logic [2:0]                 big;
    logic [2:0][DOT_W-1:0]      rem;
    logic [2:0][DIV_STEPS-1:0]  nlo;
    logic [2:0][DIV_STEPS-1:0]  q;
  } dstage_t;

endpackage

/* sv/vertex_transform_coord_unit.sv */
// Vertex transform unit: point (x, y, z, 1) times a 4x4 Q16.16 matrix,
// then perspective divide of x', y', z' by w, saturated to Q16.16.
// Input channel in_*: tdata carries point_x, point_y, point_z; tlast marks
// the last point of a batch. Output channel out_*: tdata carries result_x,
// result_y, result_z; tuser carries divide_by_zero and overflow; tlast is
// the copied batch mark.
// Matrix lives in eight 64-bit APB registers at byte address 8*i, two
// coefficients each, lower column in the low half. Reset loads identity.
// Throughput: one point per cycle while the receiver does not stall. Pipeline:
// 37 register stages: 2 multiply/sum stages, 1 divide set-up stage,
// 33 restoring divide stages of one quotient bit each, 1 output register;
// the first stage loads at the accepting edge.
// Whole pipeline advances as one when the output register is free or being
// taken; a stalled receiver freezes every stage, nothing lost or repeated.
// Reset clears all valid bits and loads the identity matrix; no transaction
// is pending.
module vertex_transform_coord_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // result_x[31:0], result_y[63:32], result_z[95:64]
  output logic [1:0]   out_tuser,  // divide_by_zero[0], overflow[1]
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import vtc_pkg::*;

  cfg_regs_t  regs_r;
  mat_t       m;
  logic       en;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = regs_r[cfg_paddr[5:3]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // identity: regs 7 down to 0
      regs_r <= {64'h0001_0000_0000_0000, 64'h0,
                 64'h0000_0000_0001_0000, 64'h0,
                 64'h0,                   64'h0001_0000_0000_0000,
                 64'h0,                   64'h0000_0000_0001_0000};
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      regs_r[cfg_paddr[5:3]] <= cfg_pwdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r][0] = regs_r[3'(r*2)][31:0];
      m[r][1] = regs_r[3'(r*2)][63:32];
      m[r][2] = regs_r[3'(r*2+1)][31:0];
      m[r][3] = regs_r[3'(r*2+1)][63:32];
    end
  end

  // global advance: output register free or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- dot products ----------------
  coord_t [2:0] p;
  dot_t   [3:0] d;
  logic         dot_valid, dot_last;

  assign p[0] = in_tdata[31:0];
  assign p[1] = in_tdata[63:32];
  assign p[2] = in_tdata[95:64];

  vtc_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .p         (p),
    .in_last   (in_tlast),
    .m         (m),
    .out_valid (dot_valid),
    .d         (d),
    .out_last  (dot_last)
  );

  // ---------------- divide set-up ----------------
  // magnitudes, sign of result, zero divisor, and the early check for
  // a quotient of 2^33 or more (numerator*2^16 >= divisor*2^33)
  dstage_t          ds_r [DIV_STEPS+1];
  logic             dv_r [DIV_STEPS+1];
  dstage_t          s0_nxt;
  mag_t [2:0]       an;

  always_comb begin
    s0_nxt      = '0;
    s0_nxt.last = dot_last;
    s0_nxt.dz   = (d[3] == '0);
    s0_nxt.ad   = d[3][DOT_W-1] ? mag_t'(-d[3]) : mag_t'(d[3]);
    for (int c = 0; c < 3; c++) begin
      an[c]            = d[c][DOT_W-1] ? mag_t'(-d[c]) : mag_t'(d[c]);
      s0_nxt.neg[c]    = d[c][DOT_W-1] ^ d[3][DOT_W-1];
      s0_nxt.big[c]    = ({17'd0, an[c]} >= {s0_nxt.ad, 17'd0});
      s0_nxt.rem[c]    = s0_nxt.big[c] ? '0 : {17'd0, an[c][DOT_W-1:17]};
      s0_nxt.nlo[c]    = {an[c][16:0], 16'd0};
      s0_nxt.q[c]      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= dot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0] <= s0_nxt;
    end
  end

  // ---------------- restoring divide, one bit per stage ----------------
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    dstage_t        sn;
    mag_t  [2:0]    rn;
    logic  [2:0]    qb;

    for (genvar c = 0; c < 3; c++) begin : g_lane
      vtc_div_step u_step (
        .rem     (ds_r[k].rem[c]),
        .nbit    (ds_r[k].nlo[c][DIV_STEPS-1]),
        .ad      (ds_r[k].ad),
        .rem_nxt (rn[c]),
        .qbit    (qb[c])
      );
    end

    always_comb begin
      sn = ds_r[k];
      for (int c = 0; c < 3; c++) begin
        sn.rem[c] = rn[c];
        sn.nlo[c] = {ds_r[k].nlo[c][DIV_STEPS-2:0], 1'b0};
        sn.q[c]   = {ds_r[k].q[c][DIV_STEPS-2:0], qb[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[k+1] <= sn;
      end
    end
  end

  // ---------------- sign, saturation, output register ----------------
  dstage_t          fin;
  logic [2:0][31:0] res;
  logic [2:0]       sat;
  logic             out_valid_r, last_r, dz_r, ovf_r;
  logic [95:0]      data_r;

  assign fin = ds_r[DIV_STEPS];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!fin.neg[c]) begin
        sat[c] = fin.big[c] || (fin.q[c] > 33'h0_7FFF_FFFF);
        res[c] = sat[c] ? 32'h7FFF_FFFF : fin.q[c][31:0];
      end else begin
        sat[c] = fin.big[c] || (fin.q[c] > 33'h0_8000_0000);
        res[c] = sat[c] ? 32'h8000_0000 : 32'(-fin.q[c]);
      end
      if (fin.dz) begin
        sat[c] = 1'b0;
        res[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= {res[2], res[1], res[0]};
      last_r <= fin.last;
      dz_r   <= fin.dz;
      ovf_r  <= |sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = {ovf_r, dz_r};
  assign out_tlast  = last_r;

endmodule

/* sv/vtc_div_step.sv */
module vtc_div_step (
  input  vtc_pkg::mag_t rem,
  input  logic          nbit,
  input  vtc_pkg::mag_t ad,
  output vtc_pkg::mag_t rem_nxt,
  output logic          qbit
);
  import vtc_pkg::*;

  logic [DOT_W:0] t;
  logic [DOT_W:0] diff;

  // one restoring step: shift in a numerator bit, subtract if it fits
  always_comb begin
    t       = {rem, nbit};
    diff    = t - {1'b0, ad};
    qbit    = (t >= {1'b0, ad});
    rem_nxt = qbit ? diff[DOT_W-1:0] : t[DOT_W-1:0];
  end

endmodule

/* sv/vtc_dot.sv */
module vtc_dot (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  vtc_pkg::coord_t [2:0]  p,
  input  logic                   in_last,
  input  vtc_pkg::mat_t          m,
  output logic                   out_valid,
  output vtc_pkg::dot_t [3:0]    d,
  output logic                   out_last
);
  import vtc_pkg::*;

  logic                           va_r, vb_r;
  logic                           la_r, lb_r;
  logic signed [2:0][3:0][63:0]   prod_r;
  logic signed [3:0][31:0]        t3_r;
  dot_t [3:0]                     d_r;
  dot_t [3:0]                     d_nxt;

  // stage A: twelve products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la_r <= in_last;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r][c] <= $signed(m[r][c]) * $signed(p[r]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        t3_r[c] <= m[3][c];
      end
    end
  end

  // stage B: floor each product to Q16.16 and sum per column, adding row 3
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      d_nxt[c] = DOT_W'($signed(t3_r[c]))
               + DOT_W'($signed(prod_r[0][c][63:Q_SHIFT]))
               + DOT_W'($signed(prod_r[1][c][63:Q_SHIFT]))
               + DOT_W'($signed(prod_r[2][c][63:Q_SHIFT]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lb_r <= la_r;
      d_r  <= d_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_last  = lb_r;
  assign d         = d_r;

endmodule
